// File: src/khbi_pkg.sv
//------------------------------------------------------------------------------
// khbi_pkg
// Shared types, constants and micro-op tables for the key hash bucket index
// block.
//------------------------------------------------------------------------------
`default_nettype none

package khbi_pkg;

  // Field widths
  localparam int unsigned KHBI_BYTE_W    = 8;
  localparam int unsigned KHBI_HASH_W    = 32;
  localparam int unsigned KHBI_IDX_W     = 16;
  localparam int unsigned KHBI_DIV_W     = 17;
  localparam int unsigned KHBI_SHAMT_W   = 5;
  localparam int unsigned KHBI_STEP_W    = 3;
  localparam int unsigned KHBI_CFG_IDX_W = 1;
  localparam int unsigned KHBI_CFG_DAT_W = 17;
  localparam int unsigned KHBI_SEL_W     = 2;
  localparam int unsigned KHBI_CNT_W     = $clog2(KHBI_HASH_W);

  // Defaults
  localparam longint unsigned KHBI_MAX_BUCKETS = 64'd65536;
  localparam logic [KHBI_DIV_W-1:0]  KHBI_BUCKETS_RST = 17'd16;
  localparam logic [KHBI_HASH_W-1:0] KHBI_FNV_SEED    = 32'd2166136261;

  // Register indexes
  typedef enum logic [KHBI_CFG_IDX_W-1:0] {
    CFG_HASH_SELECT  = 1'b0,
    CFG_BUCKET_COUNT = 1'b1
  } khbi_cfg_idx_t;

  // Hash modes; code 3 is served as shift-and-add
  typedef enum logic [KHBI_SEL_W-1:0] {
    HSEL_JENKINS   = 2'd0,
    HSEL_FNV       = 2'd1,
    HSEL_SHIFT_ADD = 2'd2
  } khbi_hsel_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_FINISH,
    ST_MODULO,
    ST_DELIVER
  } khbi_state_t;

  // Shared unit operations
  typedef enum logic [0:0] {
    ALU_ADD_SHL = 1'b0,  // x + (y << s)
    ALU_XOR_SHR = 1'b1   // x ^ (y >> s)
  } khbi_alu_op_t;

  // Operand sources
  typedef enum logic [1:0] {
    SRC_H,
    SRC_T,
    SRC_B
  } khbi_src_t;

  typedef struct packed {
    khbi_alu_op_t            op;
    khbi_src_t               xsrc;
    khbi_src_t               ysrc;
    logic [KHBI_SHAMT_W-1:0] shamt;
    logic                    last;
  } khbi_uop_t;

  // Byte fold sequence for each mode
  function automatic khbi_uop_t khbi_fold_op(input logic [KHBI_SEL_W-1:0] mode,
                                             input logic [KHBI_STEP_W-1:0] step);
    khbi_uop_t u;
    u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_B, shamt: 5'd0, last: 1'b1};
    case (khbi_hsel_t'(mode))
      HSEL_JENKINS: begin
        case (step)
          3'd0:    u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_B, shamt: 5'd0,  last: 1'b0};
          3'd1:    u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_H, shamt: 5'd10, last: 1'b0};
          default: u = '{op: ALU_XOR_SHR, xsrc: SRC_H, ysrc: SRC_H, shamt: 5'd6,  last: 1'b1};
        endcase
      end
      HSEL_FNV: begin
        // h*16777619 = t + t<<1 + t<<4 + t<<7 + t<<8 + t<<24, then xor byte
        case (step)
          3'd0:    u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_T, shamt: 5'd1,  last: 1'b0};
          3'd1:    u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_T, shamt: 5'd4,  last: 1'b0};
          3'd2:    u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_T, shamt: 5'd7,  last: 1'b0};
          3'd3:    u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_T, shamt: 5'd8,  last: 1'b0};
          3'd4:    u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_T, shamt: 5'd24, last: 1'b0};
          default: u = '{op: ALU_XOR_SHR, xsrc: SRC_H, ysrc: SRC_B, shamt: 5'd0,  last: 1'b1};
        endcase
      end
      default: begin
        u = '{op: ALU_ADD_SHL, xsrc: SRC_B, ysrc: SRC_H, shamt: 5'd8, last: 1'b1};
      end
    endcase
    return u;
  endfunction

  // Jenkins finalization sequence
  function automatic khbi_uop_t khbi_finish_op(input logic [KHBI_STEP_W-1:0] step);
    khbi_uop_t u;
    case (step)
      3'd0:    u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_H, shamt: 5'd3,  last: 1'b0};
      3'd1:    u = '{op: ALU_XOR_SHR, xsrc: SRC_H, ysrc: SRC_H, shamt: 5'd11, last: 1'b0};
      default: u = '{op: ALU_ADD_SHL, xsrc: SRC_H, ysrc: SRC_H, shamt: 5'd15, last: 1'b1};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: src/khbi_if.sv
//------------------------------------------------------------------------------
// khbi_if
// Valid/ready channel interfaces: key bytes in, hash results out, and the
// configuration write channel.
//------------------------------------------------------------------------------
`default_nettype none

interface khbi_in_if import khbi_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [KHBI_BYTE_W-1:0] key_byte;
  logic                   last_byte;

  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink   (input valid, input key_byte, input last_byte, output ready);
endinterface

interface khbi_out_if import khbi_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [KHBI_HASH_W-1:0] hash_value;
  logic [KHBI_IDX_W-1:0]  bucket_index;

  modport source (output valid, output hash_value, output bucket_index, input ready);
  modport sink   (input valid, input hash_value, input bucket_index, output ready);
endinterface

interface khbi_cfg_if import khbi_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [KHBI_CFG_IDX_W-1:0] index;
  logic [KHBI_CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/khbi_alu.sv
//------------------------------------------------------------------------------
// khbi_alu
// Shared shift unit: one shifted add or one shifted xor per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module khbi_alu import khbi_pkg::*; (
  input  khbi_alu_op_t            op,
  input  logic [KHBI_HASH_W-1:0]  x,
  input  logic [KHBI_HASH_W-1:0]  y,
  input  logic [KHBI_SHAMT_W-1:0] shamt,
  output logic [KHBI_HASH_W-1:0]  res
);

  always_comb begin
    case (op)
      ALU_ADD_SHL: res = x + (y << shamt);
      ALU_XOR_SHR: res = x ^ (y >> shamt);
      default:     res = x;
    endcase
  end

endmodule

`default_nettype wire

// File: src/khbi_mod_unit.sv
//------------------------------------------------------------------------------
// khbi_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module khbi_mod_unit import khbi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [KHBI_HASH_W-1:0] dividend,
  input  logic [KHBI_DIV_W-1:0]  divisor,
  output logic                  done,
  output logic [KHBI_DIV_W-1:0]  remainder
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [KHBI_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [KHBI_HASH_W-1:0] dvd_r, dvd_nxt;
  logic [KHBI_DIV_W-1:0]  div_r, div_nxt;
  logic [KHBI_DIV_W-1:0]  rem_r, rem_nxt;
  logic [KHBI_DIV_W:0]    trial;
  logic [KHBI_DIV_W:0]    diff;

  // Shift in the next dividend bit, subtract when it fits
  assign trial = {rem_r, dvd_r[KHBI_HASH_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      rem_nxt = (trial >= {1'b0, div_r}) ? diff[KHBI_DIV_W-1:0] : trial[KHBI_DIV_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == KHBI_CNT_W'(KHBI_HASH_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: src/key_hash_bucket_index.sv
// Hashes a key one byte per input item and, on the byte marked last, returns
// the 32-bit hash and the hash modulo the bucket count. All arithmetic runs
// through one shared shift unit stepped by a small sequencer, and the
// remainder comes from a bit-serial unit; the block takes no byte while it
// works. Each byte steps through its mode's fold sequence in the shift
// unit; in FNV-1 mode the multiply is a chain of shifted adds. After the
// last byte, Jenkins mode runs its finalization steps, then the remainder
// unit takes in one hash bit per step and the result is loaded into the
// output register. A finished result waits in that register while the
// next key's bytes are taken.
//------------------------------------------------------------------------------
// key_hash_bucket_index
// Per-byte running hash (Jenkins one-at-a-time, FNV-1, shift-and-add) with
// reduction to a bucket index.
//------------------------------------------------------------------------------
`default_nettype none

module key_hash_bucket_index import khbi_pkg::*; #(
  parameter longint unsigned MAX_BUCKETS = KHBI_MAX_BUCKETS
) (
  input  logic       clk,
  input  logic       rst_n,
  khbi_in_if.sink    in_ch,
  khbi_out_if.source out_ch,
  khbi_cfg_if.sink   cfg_ch
);

  khbi_state_t state_r, state_nxt;

  logic [KHBI_SEL_W-1:0]  hash_sel_r;
  logic [KHBI_DIV_W-1:0]  bkt_cnt_r;
  logic                   inside_r;
  logic [KHBI_STEP_W-1:0] step_r;
  logic [KHBI_SEL_W-1:0]  mode_r;
  logic [KHBI_BYTE_W-1:0] b_r;
  logic                   last_r;
  logic [KHBI_HASH_W-1:0] h_r;
  logic [KHBI_HASH_W-1:0] t_r;
  logic                   out_valid_r;
  logic [KHBI_HASH_W-1:0] out_hash_r;
  logic [KHBI_IDX_W-1:0]  out_idx_r;

  logic                   in_acc;
  logic                   cfg_acc;
  logic                   out_free;
  khbi_uop_t              uop;
  logic [KHBI_HASH_W-1:0] alu_x;
  logic [KHBI_HASH_W-1:0] alu_y;
  logic [KHBI_HASH_W-1:0] alu_res;
  logic                   alu_en;
  logic                   mod_start;
  logic                   mod_done;
  logic [KHBI_DIV_W-1:0]  mod_rem;
  logic [KHBI_DIV_W-1:0]  divisor;
  logic [KHBI_HASH_W-1:0] start_hash;
  logic                   load_out;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Effective bucket count: zero reads as one, saturate at MAX_BUCKETS
  always_comb begin
    if (bkt_cnt_r == '0) begin
      divisor = KHBI_DIV_W'(1);
    end else if ({16'd0, bkt_cnt_r} > MAX_BUCKETS[KHBI_HASH_W:0]) begin
      divisor = MAX_BUCKETS[KHBI_DIV_W-1:0];
    end else begin
      divisor = bkt_cnt_r;
    end
  end

  // Seed at start of key
  always_comb begin
    if (inside_r) begin
      start_hash = h_r;
    end else if (khbi_hsel_t'(hash_sel_r) == HSEL_FNV) begin
      start_hash = KHBI_FNV_SEED;
    end else begin
      start_hash = '0;
    end
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    alu_en      = 1'b0;
    mod_start   = 1'b0;
    load_out    = 1'b0;
    uop         = khbi_fold_op(mode_r, step_r);
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_FOLD: begin
        alu_en    = 1'b1;
        mod_start = uop.last && last_r && (khbi_hsel_t'(mode_r) != HSEL_JENKINS);
      end
      ST_FINISH: begin
        uop       = khbi_finish_op(step_r);
        alu_en    = 1'b1;
        mod_start = uop.last;
      end
      ST_MODULO: begin
      end
      ST_DELIVER: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (uop.last) begin
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else if (khbi_hsel_t'(mode_r) == HSEL_JENKINS) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_MODULO;
          end
        end
      end
      ST_FINISH: begin
        if (uop.last) state_nxt = ST_MODULO;
      end
      ST_MODULO: begin
        if (mod_done) state_nxt = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Operand select for the shared unit
  function automatic logic [KHBI_HASH_W-1:0] pick(input khbi_src_t src,
                                                  input logic [KHBI_HASH_W-1:0] h,
                                                  input logic [KHBI_HASH_W-1:0] t,
                                                  input logic [KHBI_BYTE_W-1:0] b);
    logic [KHBI_HASH_W-1:0] v;
    case (src)
      SRC_H:   v = h;
      SRC_T:   v = t;
      SRC_B:   v = {{(KHBI_HASH_W-KHBI_BYTE_W){1'b0}}, b};
      default: v = h;
    endcase
    return v;
  endfunction

  assign alu_x = pick(uop.xsrc, h_r, t_r, b_r);
  assign alu_y = pick(uop.ysrc, h_r, t_r, b_r);

  khbi_alu u_alu (
    .op    (uop.op),
    .x     (alu_x),
    .y     (alu_y),
    .shamt (uop.shamt),
    .res   (alu_res)
  );

  khbi_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (alu_res),
    .divisor   (divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_sel_r  <= HSEL_JENKINS;
      bkt_cnt_r   <= KHBI_BUCKETS_RST;
      inside_r    <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        case (khbi_cfg_idx_t'(cfg_ch.index))
          CFG_HASH_SELECT:  hash_sel_r <= cfg_ch.data[KHBI_SEL_W-1:0];
          CFG_BUCKET_COUNT: bkt_cnt_r  <= cfg_ch.data[KHBI_DIV_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        inside_r <= 1'b1;
        step_r   <= '0;
      end else if (alu_en) begin
        step_r <= uop.last ? '0 : step_r + 1'b1;
        if ((state_r == ST_FOLD) && uop.last && last_r) inside_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= hash_sel_r;
      b_r    <= in_ch.key_byte;
      last_r <= in_ch.last_byte;
      h_r    <= start_hash;
      t_r    <= start_hash;
    end else if (alu_en) begin
      h_r <= alu_res;
    end
    if (load_out) begin
      out_hash_r <= h_r;
      out_idx_r  <= mod_rem[KHBI_IDX_W-1:0];
    end
  end

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.hash_value   = out_hash_r;
  assign out_ch.bucket_index = out_idx_r;

endmodule

`default_nettype wire

// File: src/khbi_checker.sv
//------------------------------------------------------------------------------
// khbi_checker
// Port-level checks on the key hash bucket index block, bound to the top.
//------------------------------------------------------------------------------
`default_nettype none

module khbi_checker import khbi_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [KHBI_HASH_W-1:0] hash_value,
  input logic [KHBI_IDX_W-1:0]  bucket_index
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hash_value) && $stable(bucket_index))
    else $error("result changed while stalled");

  // One byte at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous byte in work");

  // A new result only appears from the busy sequencer
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind key_hash_bucket_index khbi_checker u_khbi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .hash_value   (out_ch.hash_value),
  .bucket_index (out_ch.bucket_index)
);

`default_nettype wire

// File: bench/key_hash_bucket_index_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// key_hash_bucket_index_tb
// Streams key bytes through the hash block under every hash mode and a range
// of bucket counts, predicts each finished key's hash and bucket index in
// step with the accepted bytes, and checks every result as it leaves the
// block. Both channels idle at random; one phase holds the output off long
// enough to back the block up into its input.
//------------------------------------------------------------------------------
module key_hash_bucket_index_tb;
  import khbi_pkg::*;

  localparam logic [31:0] FNV_MULTIPLIER   = 32'd16777619;
  localparam int          MAX_IDLE         = 8;
  // bytes without a last mark can still be folding after the last result
  localparam int          KEY_SETTLE_CYCLES = 16;
  localparam int          TAIL_CYCLES       = 60;

  typedef struct packed {
    logic [KHBI_HASH_W-1:0] hash_value;
    logic [KHBI_IDX_W-1:0]  bucket_index;
  } key_result_t;

  logic clk = 1'b0;
  logic rst_n;

  khbi_in_if  in_ch ();
  khbi_out_if out_ch ();
  khbi_cfg_if cfg_ch ();

  key_hash_bucket_index dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the block's state and registers
  logic [KHBI_HASH_W-1:0] key_hash;
  logic                   key_open;
  logic [KHBI_SEL_W-1:0]  hash_mode;
  logic [KHBI_DIV_W-1:0]  bucket_reg;

  key_result_t expected_hashes[$];
  int          mismatch_count = 0;

  // Idle controls for the sender and receiver
  int max_gap   = MAX_IDLE;
  int max_stall = MAX_IDLE;
  int stall_left = 0;
  int hold_left  = 0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout
  initial begin
    #5000000;
    $display("key_hash_bucket_index test failed");
    $finish;
  end

  //----------------------------------------------------------------------------
  // Prediction
  //----------------------------------------------------------------------------

  function automatic logic [31:0] fold_key_byte(input logic [31:0] h,
                                                input logic [7:0]  b,
                                                input logic [1:0]  mode);
    logic [31:0] r;
    case (khbi_hsel_t'(mode))
      HSEL_JENKINS: begin
        r = h + {24'd0, b};
        r = r + (r << 10);
        r = r ^ (r >> 6);
      end
      HSEL_FNV: begin
        r = h * FNV_MULTIPLIER;
        r = r ^ {24'd0, b};
      end
      // shift-and-add, also taken by the spare code
      default: r = (h << 8) + {24'd0, b};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] jenkins_avalanche(input logic [31:0] h);
    logic [31:0] r;
    r = h + (h << 3);
    r = r ^ (r >> 11);
    r = r + (r << 15);
    return r;
  endfunction

  function automatic logic [15:0] bucket_of(input logic [31:0] h,
                                            input logic [16:0] count);
    logic [31:0] n;
    logic [31:0] rem;
    n = {15'd0, count};
    if (n == 0) n = 1;
    if (n > 32'(KHBI_MAX_BUCKETS)) n = 32'(KHBI_MAX_BUCKETS);
    rem = h % n;
    return rem[15:0];
  endfunction

  // Fold one accepted byte; a last byte closes the key and queues its result
  task automatic fold_accepted(input logic [7:0] kb, input logic lb);
    key_result_t r;
    logic [31:0] h;
    if (!key_open) begin
      key_hash = (khbi_hsel_t'(hash_mode) == HSEL_FNV) ? KHBI_FNV_SEED : 32'd0;
      key_open = 1'b1;
    end
    key_hash = fold_key_byte(key_hash, kb, hash_mode);
    if (lb) begin
      h = key_hash;
      if (khbi_hsel_t'(hash_mode) == HSEL_JENKINS) h = jenkins_avalanche(h);
      r.hash_value   = h;
      r.bucket_index = bucket_of(h, bucket_reg);
      expected_hashes.push_back(r);
      key_hash = 32'd0;
      key_open = 1'b0;
    end
  endtask

  //----------------------------------------------------------------------------
  // Drivers; every task starts and ends on a falling edge
  //----------------------------------------------------------------------------

  task automatic send_key_byte(input logic [7:0] kb, input logic lb);
    int gap;
    gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.key_byte  = kb;
    in_ch.last_byte = lb;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    fold_accepted(kb, lb);
    @(negedge clk);
  endtask

  // Stop offering bytes and wait for every queued result
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_hashes.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input khbi_cfg_idx_t idx, input logic [16:0] value);
    wait_drained();
    repeat (KEY_SETTLE_CYCLES) @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_HASH_SELECT) hash_mode = value[1:0];
    else bucket_reg = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_key(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_key_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Receiver: long hold-off first, then the per-result stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    key_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected result hash %08h bucket %0d", $time,
                 out_ch.hash_value, out_ch.bucket_index);
        mismatch_count++;
      end else begin
        exp_r = expected_hashes.pop_front();
        if (out_ch.hash_value !== exp_r.hash_value) begin
          $display("%0t: hash_value expected %08h actual %08h", $time,
                   exp_r.hash_value, out_ch.hash_value);
          mismatch_count++;
        end
        if (out_ch.bucket_index !== exp_r.bucket_index) begin
          $display("%0t: bucket_index expected %0d actual %0d", $time,
                   exp_r.bucket_index, out_ch.bucket_index);
          mismatch_count++;
        end
      end
      stall_left = (max_stall > 0) ? $urandom_range(0, max_stall) : 0;
    end
  end

  //----------------------------------------------------------------------------
  // Tests
  //----------------------------------------------------------------------------

  // Reset settings: Jenkins, 16 buckets; byte extremes, one-byte keys and a three-byte key
  task automatic test_reset_defaults();
    send_key('{8'h00});
    send_key('{8'hFF});
    send_key('{8'h01, 8'h80, 8'h7F});
  endtask

  // FNV-1 and shift-and-add modes, and the spare selector code
  task automatic test_hash_modes();
    write_register(CFG_HASH_SELECT, 17'(HSEL_FNV));
    send_key('{8'hFF, 8'h00});
    write_register(CFG_HASH_SELECT, 17'(HSEL_SHIFT_ADD));
    send_key('{8'hAA, 8'h55, 8'hFF, 8'h01, 8'h80});
    write_register(CFG_HASH_SELECT, 17'd3);
    send_key('{8'h12, 8'hED});
  endtask

  // Zero, one, full and oversized bucket counts
  task automatic test_bucket_limits();
    write_register(CFG_HASH_SELECT, 17'(HSEL_JENKINS));
    write_register(CFG_BUCKET_COUNT, 17'd0);
    send_key('{8'h5A});
    write_register(CFG_BUCKET_COUNT, 17'd1);
    send_key('{8'hC3});
    write_register(CFG_BUCKET_COUNT, 17'd65536);
    send_key('{8'h3C, 8'h99});
    write_register(CFG_BUCKET_COUNT, 17'h1FFFF);
    send_key('{8'hE7});
  endtask

  // Seed follows the first byte's mode, finalization the last byte's
  task automatic test_mode_switch_mid_key();
    write_register(CFG_BUCKET_COUNT, 17'd1000);
    write_register(CFG_HASH_SELECT, 17'(HSEL_FNV));
    send_key_byte(8'h41, 1'b0);
    send_key_byte(8'h42, 1'b0);
    write_register(CFG_HASH_SELECT, 17'(HSEL_SHIFT_ADD));
    send_key_byte(8'h43, 1'b0);
    write_register(CFG_HASH_SELECT, 17'(HSEL_JENKINS));
    send_key_byte(8'h44, 1'b1);
    send_key_byte(8'h10, 1'b0);
    write_register(CFG_HASH_SELECT, 17'(HSEL_FNV));
    send_key_byte(8'h20, 1'b1);
  endtask

  // Output held off while bytes keep coming, then a full drain
  task automatic test_backpressure();
    int i;
    max_gap = 0;
    hold_left = 400;
    for (i = 0; i < 24; i++) send_key_byte(8'($urandom), 1'($urandom_range(0, 1)));
    send_key_byte(8'($urandom), 1'b1);
    wait_drained();
    max_gap = MAX_IDLE;
  endtask

  // Random keys over random settings
  task automatic test_random_keys();
    int phase, n, last_odds;
    logic [16:0] count;
    for (phase = 0; phase < 16; phase++) begin
      write_register(CFG_HASH_SELECT,
                     {15'($urandom), 2'($urandom_range(0, 3))});
      case ($urandom_range(0, 3))
        0:       count = 17'($urandom_range(1, 64));
        1:       count = 17'd1 << $urandom_range(0, 16);
        default: count = 17'($urandom);
      endcase
      write_register(CFG_BUCKET_COUNT, count);
      // every fourth phase runs with no idling on either side
      max_gap   = (phase % 4 == 3) ? 0 : MAX_IDLE;
      max_stall = (phase % 4 == 3) ? 0 : MAX_IDLE;
      last_odds = $urandom_range(1, 8);
      for (n = 0; n < 125; n++)
        send_key_byte(8'($urandom), $urandom_range(0, last_odds - 1) == 0);
    end
    max_gap   = MAX_IDLE;
    max_stall = MAX_IDLE;
  endtask

  //----------------------------------------------------------------------------
  // Sequence
  //----------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.key_byte   = '0;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_HASH_SELECT;
    cfg_ch.data      = '0;
    key_hash         = '0;
    key_open         = 1'b0;
    hash_mode        = 2'(HSEL_JENKINS);
    bucket_reg       = KHBI_BUCKETS_RST;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_hash_modes();
    test_bucket_limits();
    test_mode_switch_mid_key();
    test_backpressure();
    test_random_keys();

    // close any open key, then drain and watch for stray results
    send_key_byte(8'($urandom), 1'b1);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_hashes.size() == 0) begin
      $display("key_hash_bucket_index test passed");
    end else begin
      $display("key_hash_bucket_index test failed");
    end
    $finish;
  end

endmodule
